@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the trigger timer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while in reset
`define CSTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cstf assertion failed");

// next-cycle implication, masked while in reset
`define CSTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cstf assertion failed");

`endif

@@ hdl/cstf_pkg.sv @@
// ----------------------------------------------------------------------------
// cstf_pkg
// types and codes shared by the camera trigger timer modules
// ----------------------------------------------------------------------------
package cstf_pkg;

  localparam int unsigned DurW    = 32;
  localparam int unsigned ShortW  = 16;
  localparam int unsigned CfgAddrW = 2;

  localparam logic [DurW-1:0] DefaultExposeMs = 32'd100;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_EXPOSE = 3'd1,
    OP_FOCUS  = 3'd2,
    OP_DELAY  = 3'd3,
    OP_STOP   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_EXP_BEGIN = 3'd1,
    EV_FOC_BEGIN = 3'd2,
    EV_DLY_BEGIN = 3'd3,
    EV_EXP_DONE  = 3'd4,
    EV_FOC_DONE  = 3'd5,
    EV_DLY_DONE  = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_EXPOSE = 2'd1,
    ACT_FOCUS  = 2'd2,
    ACT_DELAY  = 2'd3
  } action_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_DEFAULT_EXPOSE = 2'd0,
    REG_DEFAULT_FOCUS  = 2'd1,
    REG_DEFAULT_WAIT   = 2'd2,
    REG_FOCUS_W_SHUT   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DurW-1:0]   expose_ms;
    logic [ShortW-1:0] focus_ms;
    logic [ShortW-1:0] wait_ms;
    logic              focus_with_shutter;
  } cfg_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       shutter_line;
    logic       focus_line;
    logic       busy;
  } result_t;

  typedef struct packed {
    logic busy;
    logic rem_zero;
  } status_t;

endpackage

@@ hdl/cstf_cfg.sv @@
// ----------------------------------------------------------------------------
// cstf_cfg
// configuration register file for default lengths and focus mode
// ----------------------------------------------------------------------------
module cstf_cfg
  import cstf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [DurW-1:0]     cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expose_ms          <= DefaultExposeMs;
      cfg_r.focus_ms           <= '0;
      cfg_r.wait_ms            <= '0;
      cfg_r.focus_with_shutter <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DEFAULT_EXPOSE: cfg_r.expose_ms          <= cfg_wdata;
        REG_DEFAULT_FOCUS:  cfg_r.focus_ms           <= cfg_wdata[ShortW-1:0];
        REG_DEFAULT_WAIT:   cfg_r.wait_ms            <= cfg_wdata[ShortW-1:0];
        REG_FOCUS_W_SHUT:   cfg_r.focus_with_shutter <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/cstf_core.sv @@
// ----------------------------------------------------------------------------
// cstf_core
// action state, countdown and line levels; one item per step
// ----------------------------------------------------------------------------
module cstf_core
  import cstf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  logic [2:0]      opcode,
  input  logic [DurW-1:0] duration_ms,
  input  logic            use_default,
  input  cfg_t            cfg,
  output result_t         res,
  output status_t         status
);

  action_t         act_r, act_nxt;
  logic [DurW-1:0] rem_r, rem_nxt;
  logic            shut_r, shut_nxt;
  logic            foc_r, foc_nxt;

  always_comb begin
    logic [DurW-1:0]   rem_dec;
    logic [DurW-1:0]   exp_len;
    logic [ShortW-1:0] foc_len;
    logic [ShortW-1:0] dly_len;
    logic              do_halt;
    event_t            ev;

    act_nxt  = act_r;
    rem_nxt  = rem_r;
    shut_nxt = shut_r;
    foc_nxt  = foc_r;
    do_halt  = 1'b0;
    ev       = EV_NONE;
    rem_dec  = (rem_r != '0) ? rem_r - 1'b1 : rem_r;
    exp_len  = use_default ? cfg.expose_ms : duration_ms;
    foc_len  = use_default ? cfg.focus_ms  : duration_ms[ShortW-1:0];
    dly_len  = use_default ? cfg.wait_ms   : duration_ms[ShortW-1:0];

    case (opcode_t'(opcode))
      OP_TICK: begin
        if (act_r != ACT_NONE) begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            do_halt = 1'b1;
          end
        end
      end
      OP_EXPOSE: begin
        if (exp_len == '0) begin
          ev = EV_EXP_DONE;
        end else begin
          act_nxt  = ACT_EXPOSE;
          shut_nxt = 1'b1;
          if (cfg.focus_with_shutter) begin
            foc_nxt = 1'b1;
          end
          rem_nxt  = exp_len;
          ev       = EV_EXP_BEGIN;
        end
      end
      OP_FOCUS: begin
        if (foc_len == '0) begin
          ev = EV_FOC_DONE;
        end else begin
          act_nxt = ACT_FOCUS;
          foc_nxt = 1'b1;
          rem_nxt = {{(DurW-ShortW){1'b0}}, foc_len};
          ev      = EV_FOC_BEGIN;
        end
      end
      OP_DELAY: begin
        if (dly_len == '0) begin
          ev = EV_DLY_DONE;
        end else begin
          act_nxt = ACT_DELAY;
          rem_nxt = {{(DurW-ShortW){1'b0}}, dly_len};
          ev      = EV_DLY_BEGIN;
        end
      end
      OP_STOP: do_halt = 1'b1;
      default: ;
    endcase

    // stop, or countdown run out
    if (do_halt) begin
      case (act_r)
        ACT_EXPOSE: begin
          shut_nxt = 1'b0;
          foc_nxt  = 1'b0;
          ev       = EV_EXP_DONE;
        end
        ACT_FOCUS: begin
          foc_nxt = 1'b0;
          ev      = EV_FOC_DONE;
        end
        default: ev = EV_DLY_DONE;
      endcase
      act_nxt = ACT_NONE;
      rem_nxt = '0;
    end

    res.event_code   = ev;
    res.shutter_line = shut_nxt;
    res.focus_line   = foc_nxt;
    res.busy         = (act_nxt != ACT_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= ACT_NONE;
      rem_r  <= '0;
      shut_r <= 1'b0;
      foc_r  <= 1'b0;
    end else if (step_en) begin
      act_r  <= act_nxt;
      rem_r  <= rem_nxt;
      shut_r <= shut_nxt;
      foc_r  <= foc_nxt;
    end
  end

  assign status.busy     = (act_r != ACT_NONE);
  assign status.rem_zero = (rem_r == '0);

endmodule

@@ hdl/camera_shutter_focus_timer.sv @@
// ----------------------------------------------------------------------------
// camera_shutter_focus_timer
// camera trigger timer: ms ticks and expose/focus/delay/stop commands drive
// the shutter and focus lines and report begin/done events
// ----------------------------------------------------------------------------
// Takes one item per clock while the output side is not stalled and returns
// exactly one result item for each, through the input register and then the
// result register. A single step stage lies between the two registers and
// holds the 32-bit countdown decrement and zero compare; the result register
// lets a new item enter while a finished result still waits. Configuration
// is written through a plain write port and must only change while the
// block is idle.
module camera_shutter_focus_timer
  import cstf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_opcode,
  input  logic [DurW-1:0]     in_duration_ms,
  input  logic                in_use_default,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_event_code,
  output logic                out_shutter_line,
  output logic                out_focus_line,
  output logic                out_busy_res,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [DurW-1:0]     cfg_wdata
);

`include "assert_macros.svh"

  cfg_t            cfg;
  result_t         res;
  status_t         status;

  logic            in_valid_r;
  logic [2:0]      in_opcode_r;
  logic [DurW-1:0] in_duration_r;
  logic            in_use_default_r;

  logic            out_valid_r;
  result_t         out_res_r;

  logic            advance;

  // held item moves into the result register
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_opcode_r      <= in_opcode;
      in_duration_r    <= in_duration_ms;
      in_use_default_r <= in_use_default;
    end
  end

  cstf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cstf_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .opcode      (in_opcode_r),
    .duration_ms (in_duration_r),
    .use_default (in_use_default_r),
    .cfg         (cfg),
    .res         (res),
    .status      (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_code   = out_res_r.event_code;
  assign out_shutter_line = out_res_r.shutter_line;
  assign out_focus_line   = out_res_r.focus_line;
  assign out_busy_res     = out_res_r.busy;

  // a running action always has time left, an idle one none
  `CSTF_ASSERT_NOW(a_busy_rem, clk, rst_n, 1'b1, status.busy == !status.rem_zero)
  // a stalled result item stays offered and unchanged
  `CSTF_ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid_r && !out_ready,
    out_valid_r && $stable(out_res_r))
  // a begin result means an action runs
  `CSTF_ASSERT_NOW(a_begin_busy, clk, rst_n,
    out_valid_r && (out_res_r.event_code == EV_EXP_BEGIN ||
    out_res_r.event_code == EV_FOC_BEGIN || out_res_r.event_code == EV_DLY_BEGIN),
    out_res_r.busy)
  // a held item that cannot move stays held
  `CSTF_ASSERT_NEXT(a_hold_item, clk, rst_n, in_valid_r && !advance, in_valid_r)

endmodule

@@ test/cstf_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cstf_result_checker
// watches the item, result and register ports of the trigger timer, keeps
// its own copy of the timer state and settings, and compares every result
// item field by field against the expected one
// ----------------------------------------------------------------------------
module cstf_result_checker
  import cstf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [2:0]          in_opcode,
  input  logic [DurW-1:0]     in_duration_ms,
  input  logic                in_use_default,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [2:0]          out_event_code,
  input  logic                out_shutter_line,
  input  logic                out_focus_line,
  input  logic                out_busy_res,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [DurW-1:0]     cfg_wdata,
  output int unsigned         results_owed,
  output int unsigned         mismatch_count
);

  cfg_t            settings;
  action_t         running;
  logic [DurW-1:0] countdown;
  logic            shutter_lvl;
  logic            focus_lvl;
  result_t         owed_results[$];
  int unsigned     errs = 0;

  // ends the running action, drops its lines and gives the done code
  function automatic event_t end_action();
    event_t ev;
    case (running)
      ACT_EXPOSE: begin
        shutter_lvl = 1'b0;
        focus_lvl   = 1'b0;
        ev = EV_EXP_DONE;
      end
      ACT_FOCUS: begin
        focus_lvl = 1'b0;
        ev = EV_FOC_DONE;
      end
      // a stop with nothing running reports delay done
      default: ev = EV_DLY_DONE;
    endcase
    running   = ACT_NONE;
    countdown = '0;
    return ev;
  endfunction

  function automatic result_t timer_step(logic [2:0] op, logic [DurW-1:0] dur, logic dflt);
    event_t          ev;
    logic [DurW-1:0] len;
    result_t         res;
    ev = EV_NONE;
    case (op)
      OP_TICK: begin
        if (running != ACT_NONE) begin
          if (countdown != '0) countdown = countdown - 1'b1;
          if (countdown == '0) ev = end_action();
        end
      end
      OP_EXPOSE: begin
        len = dflt ? settings.expose_ms : dur;
        if (len == '0) begin
          ev = EV_EXP_DONE;
        end else begin
          running = ACT_EXPOSE;
          if (settings.focus_with_shutter) focus_lvl = 1'b1;
          shutter_lvl = 1'b1;
          countdown   = len;
          ev = EV_EXP_BEGIN;
        end
      end
      OP_FOCUS: begin
        len = dflt ? settings.focus_ms : dur[ShortW-1:0];
        if (len == '0) begin
          ev = EV_FOC_DONE;
        end else begin
          focus_lvl = 1'b1;
          running   = ACT_FOCUS;
          countdown = len;
          ev = EV_FOC_BEGIN;
        end
      end
      OP_DELAY: begin
        len = dflt ? settings.wait_ms : dur[ShortW-1:0];
        if (len == '0) begin
          ev = EV_DLY_DONE;
        end else begin
          // lines raised by an earlier action stay as they are
          running   = ACT_DELAY;
          countdown = len;
          ev = EV_DLY_BEGIN;
        end
      end
      OP_STOP: ev = end_action();
      default: ;
    endcase
    res.event_code   = ev;
    res.shutter_line = shutter_lvl;
    res.focus_line   = focus_lvl;
    res.busy         = (running != ACT_NONE);
    return res;
  endfunction

  function automatic int unsigned field_diff(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      settings.expose_ms          = DefaultExposeMs;
      settings.focus_ms           = '0;
      settings.wait_ms            = '0;
      settings.focus_with_shutter = 1'b0;
      running     = ACT_NONE;
      countdown   = '0;
      shutter_lvl = 1'b0;
      focus_lvl   = 1'b0;
      owed_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_DEFAULT_EXPOSE: settings.expose_ms          = cfg_wdata;
          REG_DEFAULT_FOCUS:  settings.focus_ms           = cfg_wdata[ShortW-1:0];
          REG_DEFAULT_WAIT:   settings.wait_ms            = cfg_wdata[ShortW-1:0];
          REG_FOCUS_W_SHUT:   settings.focus_with_shutter = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("result item with no expectation pending");
          errs++;
        end else begin
          want = owed_results.pop_front();
          errs += field_diff("event_code", want.event_code, out_event_code);
          errs += field_diff("shutter_line", {2'b0, want.shutter_line}, {2'b0, out_shutter_line});
          errs += field_diff("focus_line", {2'b0, want.focus_line}, {2'b0, out_focus_line});
          errs += field_diff("busy_res", {2'b0, want.busy}, {2'b0, out_busy_res});
        end
      end
      if (in_valid && in_ready)
        owed_results.push_back(timer_step(in_opcode, in_duration_ms, in_use_default));
    end
    results_owed   <= owed_results.size();
    mismatch_count <= errs;
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives ticks and expose/focus/delay/stop commands into the camera trigger
// timer under several register settings and idling patterns; the checker
// beside the block predicts and compares every result item
// ----------------------------------------------------------------------------
module tb;
  import cstf_pkg::*;

  localparam logic [2:0]  OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0]  OP_LAST_UNUSED  = 3'd7;
  localparam int unsigned DirectedItems   = 25;
  localparam int unsigned ItemsPerSegment = 296;
  localparam int unsigned Segments        = 6;
  localparam int unsigned LongHoldCycles  = 400;
  localparam int unsigned SettleCycles    = 8;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [2:0]          in_opcode      = OP_TICK;
  logic [DurW-1:0]     in_duration_ms = '0;
  logic                in_use_default = 1'b0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [2:0]          out_event_code;
  logic                out_shutter_line;
  logic                out_focus_line;
  logic                out_busy_res;
  logic                cfg_we         = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr       = REG_DEFAULT_EXPOSE;
  logic [DurW-1:0]     cfg_wdata      = '0;

  int unsigned results_owed;
  int unsigned mismatch_count;
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned hold_left    = 0;
  int unsigned items_sent   = 0;
  logic        hold_start   = 1'b0;

  always #10 clk = ~clk;

  camera_shutter_focus_timer i_dut (.*);

  cstf_result_checker i_checker (.*);

  // receiver: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_start) begin
      hold_left <= LongHoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [DurW-1:0] dur, input logic dflt);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_duration_ms <= dur;
    in_use_default <= dflt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op <= OP_STOP) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [DurW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic write_config(input logic [DurW-1:0] expose_ms, input logic [ShortW-1:0] focus_ms,
                              input logic [ShortW-1:0] wait_ms, input logic fws);
    cfg_write(REG_DEFAULT_EXPOSE, expose_ms);
    cfg_write(REG_DEFAULT_FOCUS, {16'($urandom), focus_ms});
    cfg_write(REG_DEFAULT_WAIT, {16'($urandom), wait_ms});
    cfg_write(REG_FOCUS_W_SHUT, {31'($urandom), fws});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DurW-1:0] rand_duration();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      // upper half random, low half short: focus and delay see a short length
      2: return {16'($urandom), 16'($urandom_range(0, 6))};
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [2:0] random_opcode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_TICK;
    if (r < 58) return OP_EXPOSE;
    if (r < 70) return OP_FOCUS;
    if (r < 82) return OP_DELAY;
    if (r < 95) return OP_STOP;
    return 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
  endfunction

  // mostly a command followed by ticks and maybe a stop, some loose items
  task automatic run_sequence();
    logic [2:0]  op;
    int unsigned n_ticks;
    if ($urandom_range(0, 99) < 20) begin
      send_item(random_opcode(), rand_duration(), 1'($urandom_range(0, 1)));
    end else begin
      case ($urandom_range(0, 2))
        0: op = OP_EXPOSE;
        1: op = OP_FOCUS;
        default: op = OP_DELAY;
      endcase
      send_item(op, rand_duration(), $urandom_range(0, 3) == 0);
      n_ticks = $urandom_range(0, 8);
      repeat (n_ticks) send_item(OP_TICK, $urandom, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) send_item(OP_STOP, $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned seg_start;
    bit          paused;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 35;
    out_idle_pct <= 69;

    // directed items under reset settings
    send_item(OP_TICK, '1, 1'b1);
    send_item(OP_STOP, '0, 1'b0);
    send_item(OP_EXPOSE, '0, 1'b0);
    send_item(OP_FOCUS, 32'h0001_0000, 1'b0);
    send_item(OP_DELAY, 32'hFFFF_0000, 1'b0);
    send_item(OP_FOCUS, '1, 1'b1);
    send_item(OP_DELAY, '0, 1'b1);
    send_item(OP_EXPOSE, '0, 1'b1);
    // a focus replacing an exposure leaves the shutter high
    send_item(OP_FOCUS, 32'd2, 1'b0);
    send_item(OP_TICK, '0, 1'b0);
    send_item(OP_TICK, '0, 1'b0);
    send_item(OP_STOP, '0, 1'b0);
    send_item(OP_EXPOSE, '1, 1'b0);
    send_item(OP_TICK, '0, 1'b0);
    send_item(OP_STOP, '1, 1'b1);
    send_item(OP_DELAY, 32'd1, 1'b0);
    send_item(OP_TICK, '0, 1'b0);
    send_item(OP_FOCUS, 32'h0000_FFFF, 1'b0);
    send_item(OP_STOP, '0, 1'b0);
    // zero-length command leaves the running delay alone
    send_item(OP_DELAY, 32'd2, 1'b0);
    send_item(OP_EXPOSE, '0, 1'b0);
    send_item(OP_TICK, '0, 1'b0);
    send_item(OP_TICK, '0, 1'b0);
    send_item(OP_FIRST_UNUSED, '1, 1'b1);
    send_item(OP_LAST_UNUSED, '0, 1'b0);

    for (int seg = 0; seg < Segments; seg++) begin
      wait_drained();
      case (seg)
        0: write_config(32'd3, 16'd2, 16'd4, 1'b1);
        1: write_config('0, '0, '0, 1'b0);
        2: write_config('1, '1, '1, 1'b1);
        default: write_config($urandom_range(1, 6), 16'($urandom_range(1, 6)),
                              16'($urandom_range(1, 6)), 1'($urandom_range(0, 1)));
      endcase
      case (seg / 2)
        0: begin
          in_idle_pct  = 35;
          out_idle_pct <= 69;
        end
        1: begin
          in_idle_pct  = 69;
          out_idle_pct <= 35;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct <= 0;
        end
      endcase
      if (seg == 1) begin
        // receiver holds off while the sender keeps offering items
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      seg_start = items_sent;
      while (items_sent < DirectedItems + (seg + 1) * ItemsPerSegment) begin
        run_sequence();
        if (seg == 3 && !paused && items_sent >= seg_start + 100) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
